@@ design/i2c_write_transaction_bitbang_unit_defines.svh @@
// ----------------------------------------------------------------------------
// I2C write transaction unit: assertion macros
// Concurrent assertion helpers used by the unit's top-level RTL file.
// ----------------------------------------------------------------------------
`ifndef I2C_WRITE_TRANSACTION_BITBANG_UNIT_DEFINES_SVH
`define I2C_WRITE_TRANSACTION_BITBANG_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// Check a property on a given clock, disabled while the given reset is low.
`define I2CW_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Check a property on clk_i, disabled while rst_ni is low.
`define I2CW_ASSERT(lbl, prop, msg) \
  `I2CW_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)
`else
`define I2CW_ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define I2CW_ASSERT(lbl, prop, msg)
`endif

`endif

@@ design/i2cw_pkg.sv @@
// ----------------------------------------------------------------------------
// I2C write transaction unit: package
// Action and register codes, sequence constants and shared types.
// ----------------------------------------------------------------------------
package i2cw_pkg;

  // Action codes of an input transfer
  localparam logic [1:0] ACT_TICK = 2'd0;
  localparam logic [1:0] ACT_CMD  = 2'd1;
  localparam logic [1:0] ACT_DATA = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_DEV_ADDR = 2'd0;
  localparam logic [1:0] CFG_CMD_CTL  = 2'd1;
  localparam logic [1:0] CFG_DATA_CTL = 2'd2;

  // Configuration reset values
  localparam logic [7:0] DEV_ADDR_RST = 8'd120;
  localparam logic [7:0] CMD_CTL_RST  = 8'd0;
  localparam logic [7:0] DATA_CTL_RST = 8'd64;

  // Pin sequence layout: start, three bytes, stop
  localparam logic [6:0] START_LEN = 7'd4;
  localparam logic [6:0] BYTE_LEN  = 7'd26;
  localparam logic [6:0] STOP_BASE = 7'd82;
  localparam logic [6:0] SEQ_LAST  = 7'd84;
  localparam logic [4:0] BITS_END  = 5'd24;  // 8 bits x 3 writes
  localparam logic [7:0] MSB_MASK  = 8'h80;

  typedef struct packed {
    logic [7:0] dev_addr;
    logic [7:0] cmd_ctl;
    logic [7:0] data_ctl;
  } cfg_t;

  typedef struct packed {
    logic clock;
    logic data;
    logic finished;
  } pin_step_t;

endpackage

@@ design/i2c_write_transaction_bitbang_unit.sv @@
// ----------------------------------------------------------------------------
// I2C write transaction unit
// Write-only I2C master playing an 85-write pin sequence, one write per tick.
// ----------------------------------------------------------------------------
// Dataflow: an input transfer loads the input register; the result register
//   loads from it once free, and a stalled output holds the result.
// Throughput: one transfer per cycle while the output is not stalled; the step
//   decoder and the state update sit between the input and result registers.
// Reset: lines rest high, unit idle, config registers at their defaults,
//   both pipeline registers empty.
`include "i2c_write_transaction_bitbang_unit_defines.svh"

module i2c_write_transaction_bitbang_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration write channel
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  // input channel
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] action_i,
  input  logic [7:0] payload_i,
  // result channel
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       clock_line_o,
  output logic       data_line_o,
  output logic       busy_res_o,
  output logic       finished_o,
  output logic       rejected_o
);
  import i2cw_pkg::*;

  cfg_t      cfg;
  pin_step_t pin_step;

  // Input register
  logic       in_vld_q;
  logic [1:0] action_q;
  logic [7:0] payload_q;

  // Transaction state
  logic [6:0] step_q, step_d;
  logic [7:0] held_q, held_d;
  logic       is_data_q, is_data_d;
  logic       in_prog_q, in_prog_d;
  logic       clk_lvl_q, clk_lvl_d;
  logic       dat_lvl_q, dat_lvl_d;

  // Result register
  logic out_vld_q;
  logic fin_q, fin_d;
  logic rej_q, rej_d;

  logic advance;
  logic fire;
  logic is_submit;

  // Config registers are always writable; writes must come only while idle (not enforced here)
  assign cfg_ready_o = 1'b1;

  i2cw_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Result register frees up when empty or when its transfer completes
  assign advance    = !out_vld_q || out_ready_i;
  assign in_ready_o = !in_vld_q || advance;
  assign fire       = in_vld_q && advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      action_q  <= action_i;
      payload_q <= payload_i;
    end
  end

  i2cw_step u_step (
    .clock_i    (clk_lvl_q),
    .data_i     (dat_lvl_q),
    .step_i     (step_q),
    .dev_addr_i (cfg.dev_addr),
    .ctl_byte_i (is_data_q ? cfg.data_ctl : cfg.cmd_ctl),
    .payload_i  (held_q),
    .step_o     (pin_step)
  );

  assign is_submit = (action_q == ACT_CMD) || (action_q == ACT_DATA);

  always_comb begin
    step_d    = step_q;
    held_d    = held_q;
    is_data_d = is_data_q;
    in_prog_d = in_prog_q;
    clk_lvl_d = clk_lvl_q;
    dat_lvl_d = dat_lvl_q;
    fin_d     = 1'b0;
    rej_d     = 1'b0;
    if (is_submit) begin
      if (in_prog_q) begin
        // drop a submit that lands mid-transaction
        rej_d = 1'b1;
      end else begin
        held_d    = payload_q;
        is_data_d = (action_q == ACT_DATA);
        in_prog_d = 1'b1;
        step_d    = '0;
      end
    end else if ((action_q == ACT_TICK) && in_prog_q) begin
      clk_lvl_d = pin_step.clock;
      dat_lvl_d = pin_step.data;
      fin_d     = pin_step.finished;
      if (pin_step.finished) begin
        in_prog_d = 1'b0;
        step_d    = '0;
      end else begin
        step_d = step_q + 7'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q    <= '0;
      held_q    <= '0;
      is_data_q <= 1'b0;
      in_prog_q <= 1'b0;
      clk_lvl_q <= 1'b1;
      dat_lvl_q <= 1'b1;
      out_vld_q <= 1'b0;
    end else begin
      if (advance) begin
        out_vld_q <= in_vld_q;
      end
      if (fire) begin
        step_q    <= step_d;
        held_q    <= held_d;
        is_data_q <= is_data_d;
        in_prog_q <= in_prog_d;
        clk_lvl_q <= clk_lvl_d;
        dat_lvl_q <= dat_lvl_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      fin_q <= fin_d;
      rej_q <= rej_d;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign clock_line_o = clk_lvl_q;
  assign data_line_o  = dat_lvl_q;
  assign busy_res_o   = in_prog_q;
  assign finished_o   = fin_q;
  assign rejected_o   = rej_q;

  `I2CW_ASSERT(a_fin_idle, out_valid_o && finished_o |-> !busy_res_o, "finished while busy")
  `I2CW_ASSERT(a_rej_busy, out_valid_o && rejected_o |-> busy_res_o && !finished_o, "bad reject")
  `I2CW_ASSERT(a_step_range, step_q <= SEQ_LAST, "step counter out of range")
  `I2CW_ASSERT(a_idle_step, !in_prog_q |-> step_q == '0, "step counter not cleared when idle")
  `I2CW_ASSERT(a_fin_lines, out_valid_o && finished_o |-> clock_line_o && data_line_o, "lines not released after stop")

endmodule

@@ design/i2cw_cfg.sv @@
// ----------------------------------------------------------------------------
// I2C write transaction unit: configuration registers
// Holds the address and control bytes written through the config channel.
// ----------------------------------------------------------------------------
module i2cw_cfg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [7:0]         cfg_data_i,
  output i2cw_pkg::cfg_t     cfg_o
);
  import i2cw_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dev_addr <= DEV_ADDR_RST;
      cfg_q.cmd_ctl  <= CMD_CTL_RST;
      cfg_q.data_ctl <= DATA_CTL_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_DEV_ADDR: cfg_q.dev_addr <= cfg_data_i;
        CFG_CMD_CTL:  cfg_q.cmd_ctl  <= cfg_data_i;
        CFG_DATA_CTL: cfg_q.data_ctl <= cfg_data_i;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ design/i2cw_step.sv @@
// ----------------------------------------------------------------------------
// I2C write transaction unit: pin step decoder
// Maps a step number to the clock and data levels of that pin write.
// ----------------------------------------------------------------------------
module i2cw_step (
  input  logic                  clock_i,
  input  logic                  data_i,
  input  logic [6:0]            step_i,
  input  logic [7:0]            dev_addr_i,
  input  logic [7:0]            ctl_byte_i,
  input  logic [7:0]            payload_i,
  output i2cw_pkg::pin_step_t   step_o
);
  import i2cw_pkg::*;

  logic [6:0] s;
  logic [6:0] rel;
  logic [6:0] off_w;
  logic [4:0] off;
  logic [8:0] prod;
  logic [2:0] bitn;
  logic [4:0] phase_w;
  logic [1:0] phase;
  logic [7:0] cur_byte;
  logic       cur_bit;

  always_comb begin
    // Clamp a step past the end onto the final stop write
    s   = (step_i > SEQ_LAST) ? SEQ_LAST : step_i;
    rel = s - START_LEN;
    if (rel < BYTE_LEN) begin
      off_w    = rel;
      cur_byte = dev_addr_i;
    end else if (rel < (BYTE_LEN + BYTE_LEN)) begin
      off_w    = rel - BYTE_LEN;
      cur_byte = ctl_byte_i;
    end else begin
      off_w    = rel - (BYTE_LEN + BYTE_LEN);
      cur_byte = payload_i;
    end
    off = off_w[4:0];
    // off / 3 for off < 24 as a multiply by 11/32
    prod    = {4'd0, off} * 9'd11;
    bitn    = prod[7:5];
    phase_w = off - ({2'd0, bitn} * 5'd3);
    phase   = phase_w[1:0];
    cur_bit = |(cur_byte & (MSB_MASK >> bitn));

    step_o.clock    = clock_i;
    step_o.data     = data_i;
    step_o.finished = 1'b0;

    if (s < START_LEN) begin
      case (s[1:0])
        2'd0:    step_o.clock = 1'b1;
        2'd1:    step_o.data  = 1'b1;
        2'd2:    step_o.data  = 1'b0;
        default: step_o.clock = 1'b0;
      endcase
    end else if (s < STOP_BASE) begin
      if (off < BITS_END) begin
        case (phase)
          2'd0:    step_o.data  = cur_bit;
          2'd1:    step_o.clock = 1'b1;
          default: step_o.clock = 1'b0;
        endcase
      end else if (off == BITS_END) begin
        step_o.clock = 1'b1;  // dummy acknowledge pulse
      end else begin
        step_o.clock = 1'b0;
      end
    end else if (s == STOP_BASE) begin
      step_o.data = 1'b0;
    end else if (s == (STOP_BASE + 7'd1)) begin
      step_o.clock = 1'b1;
    end else begin
      step_o.data     = 1'b1;
      step_o.finished = 1'b1;
    end
  end

endmodule
